@@ hdl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion %m failed");

// condition holds in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion %m failed");

`endif

@@ hdl/fsr_pkg.sv @@
package fsr_pkg;

	// result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_COLOR  = 2'd1;
	localparam logic [1:0] KIND_STITCH = 2'd2;

	// stitch flag codes
	localparam logic [1:0] SFLAG_NORMAL = 2'd0;
	localparam logic [1:0] SFLAG_STOP   = 2'd1;
	localparam logic [1:0] SFLAG_TRIM   = 2'd2;

	// bits of the flag byte
	localparam logic [7:0] FLAG_STOP = 8'h01;
	localparam logic [7:0] FLAG_TRIM = 8'h04;

	// byte positions inside entries and records
	localparam logic [3:0] COLOR_LAST_POS  = 4'd3;
	localparam logic [3:0] RECORD_LAST_POS = 4'd8;

	// output bus width
	localparam int TDATA_W = 128;

	// one parsed result
	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         version_byte;
		logic [7:0]         hoop_code;
		logic [23:0]        thread_color;
		logic [15:0]        color_index;
		logic signed [23:0] stitch_x;
		logic signed [23:0] stitch_y;
		logic [1:0]         stitch_flag;
		logic               unknown_flags;
		logic [15:0]        stitch_index;
		logic               last_stitch;
	} result_t;

endpackage

@@ hdl/fsr_parse.sv @@
module fsr_parse import fsr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] data_byte,
	input  logic       file_start,
	output result_t    res,
	output logic       res_valid
);

	typedef enum logic [2:0] {
		PH_VERSION = 3'd0,
		PH_HOOP    = 3'd1,
		PH_CCOUNT  = 3'd2,
		PH_COLOR   = 3'd3,
		PH_SCOUNT  = 3'd4,
		PH_STITCH  = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	phase_t      phase_q, nxt_phase, cur_phase;
	logic [3:0]  pos_q, nxt_pos;
	logic [7:0]  version_q, nxt_version;
	logic [7:0]  low_q, nxt_low;
	logic [15:0] colors_left_q, nxt_colors_left;
	logic [15:0] color_cnt_q, nxt_color_cnt;
	logic [15:0] stitches_left_q, nxt_stitches_left;
	logic [15:0] stitch_cnt_q, nxt_stitch_cnt;
	logic [23:0] color_asm_q, nxt_color_asm;
	logic [23:0] x_q, nxt_x;
	logic [23:0] y_q, nxt_y;
	logic [15:0] count_word;
	logic [15:0] colors_dec;
	logic [15:0] stitches_dec;

	// a file start restarts at the version byte; every other register is rewritten before use
	assign cur_phase    = file_start ? PH_VERSION : phase_q;
	assign count_word   = {data_byte, low_q};
	assign colors_dec   = colors_left_q - 16'd1;
	assign stitches_dec = stitches_left_q - 16'd1;

	// byte decode and result build
	always_comb begin
		nxt_phase         = cur_phase;
		nxt_pos           = pos_q;
		nxt_version       = version_q;
		nxt_low           = low_q;
		nxt_colors_left   = colors_left_q;
		nxt_color_cnt     = color_cnt_q;
		nxt_stitches_left = stitches_left_q;
		nxt_stitch_cnt    = stitch_cnt_q;
		nxt_color_asm     = color_asm_q;
		nxt_x             = x_q;
		nxt_y             = y_q;
		res               = '0;
		res_valid         = 1'b0;
		case (cur_phase)
			PH_VERSION: begin
				nxt_version = data_byte;
				nxt_phase   = PH_HOOP;
			end
			PH_HOOP: begin
				res_valid        = 1'b1;
				res.kind         = KIND_HEADER;
				res.version_byte = version_q;
				res.hoop_code    = data_byte;
				nxt_phase        = PH_CCOUNT;
				nxt_pos          = 4'd0;
			end
			PH_CCOUNT: begin
				if (pos_q == 4'd0) begin
					nxt_low = data_byte;
					nxt_pos = 4'd1;
				end else begin
					nxt_colors_left = count_word;
					nxt_color_cnt   = 16'd0;
					nxt_pos         = 4'd0;
					nxt_phase       = (count_word != 16'd0) ? PH_COLOR : PH_SCOUNT;
				end
			end
			PH_COLOR: begin
				if (pos_q < COLOR_LAST_POS) begin
					nxt_color_asm = {color_asm_q[15:0], data_byte};
					nxt_pos       = pos_q + 4'd1;
				end else begin
					// fourth byte of the entry is skipped
					res_valid        = 1'b1;
					res.kind         = KIND_COLOR;
					res.thread_color = color_asm_q;
					res.color_index  = color_cnt_q;
					nxt_color_cnt    = color_cnt_q + 16'd1;
					nxt_colors_left  = colors_dec;
					nxt_pos          = 4'd0;
					nxt_color_asm    = 24'd0;
					if (colors_dec == 16'd0) begin
						nxt_phase = PH_SCOUNT;
					end
				end
			end
			PH_SCOUNT: begin
				if (pos_q == 4'd0) begin
					nxt_low = data_byte;
					nxt_pos = 4'd1;
				end else begin
					nxt_stitches_left = count_word;
					nxt_stitch_cnt    = 16'd0;
					nxt_pos           = 4'd0;
					nxt_phase         = (count_word != 16'd0) ? PH_STITCH : PH_DONE;
				end
			end
			PH_STITCH: begin
				// byte lanes of x and y, little endian
				case (pos_q)
					4'd1: nxt_x[7:0]   = data_byte;
					4'd2: nxt_x[15:8]  = data_byte;
					4'd3: nxt_x[23:16] = data_byte;
					4'd5: nxt_y[7:0]   = data_byte;
					4'd6: nxt_y[15:8]  = data_byte;
					4'd7: nxt_y[23:16] = data_byte;
					default: ;
				endcase
				if (pos_q < RECORD_LAST_POS) begin
					if (pos_q == 4'd0) begin
						nxt_x = 24'd0;
						nxt_y = 24'd0;
					end
					nxt_pos = pos_q + 4'd1;
				end else begin
					res_valid    = 1'b1;
					res.kind     = KIND_STITCH;
					res.stitch_x = $signed(x_q);
					res.stitch_y = $signed(y_q);
					// stop wins over trim
					if ((data_byte & FLAG_STOP) != 8'd0) begin
						res.stitch_flag = SFLAG_STOP;
					end else if ((data_byte & FLAG_TRIM) != 8'd0) begin
						res.stitch_flag = SFLAG_TRIM;
					end else begin
						res.stitch_flag   = SFLAG_NORMAL;
						res.unknown_flags = (data_byte != 8'd0);
					end
					res.stitch_index  = stitch_cnt_q;
					res.last_stitch   = (stitches_dec == 16'd0);
					nxt_stitch_cnt    = stitch_cnt_q + 16'd1;
					nxt_stitches_left = stitches_dec;
					nxt_pos           = 4'd0;
					if (stitches_dec == 16'd0) begin
						nxt_phase = PH_DONE;
					end
				end
			end
			default: ;
		endcase
	end

	// parser control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_VERSION;
			pos_q           <= 4'd0;
			colors_left_q   <= 16'd0;
			color_cnt_q     <= 16'd0;
			stitches_left_q <= 16'd0;
			stitch_cnt_q    <= 16'd0;
		end else if (en) begin
			phase_q         <= nxt_phase;
			pos_q           <= nxt_pos;
			colors_left_q   <= nxt_colors_left;
			color_cnt_q     <= nxt_color_cnt;
			stitches_left_q <= nxt_stitches_left;
			stitch_cnt_q    <= nxt_stitch_cnt;
		end
	end

	// assembly registers
	always_ff @(posedge clk) begin
		if (en) begin
			version_q   <= nxt_version;
			low_q       <= nxt_low;
			color_asm_q <= nxt_color_asm;
			x_q         <= nxt_x;
			y_q         <= nxt_y;
		end
	end

endmodule

@@ hdl/fsr_out_reg.sv @@
module fsr_out_reg import fsr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	input  logic    take,
	output logic    valid,
	output result_t res_out,
	output logic    space
);

	logic    valid_q;
	result_t res_q;

	// room for a new result when empty or being emptied this cycle
	assign space   = !valid_q || take;
	assign valid   = valid_q;
	assign res_out = res_q;

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

@@ hdl/stitch_file_record_parser_top.sv @@
// Byte-serial reader for PCS embroidery files: one file byte per input item, file start in
// tuser restarts parsing at the version byte. Results are a header (after the hoop byte), one
// item per thread color entry and one per 9-byte stitch record; tuser gives the kind and
// tlast marks the final stitch. The block takes one byte per cycle at full rate; a result
// raises m_tvalid once its last byte has passed the input register and then been loaded
// into the result register. Input is held back only while a finished result waits on the
// output and the receiver is not ready.
`include "assert_macros.svh"

module stitch_file_record_parser_top import fsr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] data_byte
	input  logic [0:0]         s_tuser,   // [0] file_start
	output logic               m_tvalid,
	input  logic               m_tready,
	// [7:0] version_byte, [15:8] hoop_code, [39:16] thread_color, [55:40] color_index,
	// [79:56] stitch_x, [103:80] stitch_y, [105:104] stitch_flag, [106] unknown_flags,
	// [122:107] stitch_index, [127:123] zero
	output logic [TDATA_W-1:0] m_tdata,
	output logic [1:0]         m_tuser,   // [1:0] item_kind
	output logic               m_tlast    // last_stitch
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       start_s1;
	logic       advance;
	logic       space;
	logic       res_valid;
	result_t    res;
	result_t    res_out;

	// the parsed byte moves on when the result register has room
	assign advance  = valid_s1 && space;
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
	end

	fsr_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.data_byte  (data_s1),
		.file_start (start_s1),
		.res        (res),
		.res_valid  (res_valid)
	);

	fsr_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && res_valid),
		.res_in  (res),
		.take    (m_tready),
		.valid   (m_tvalid),
		.res_out (res_out),
		.space   (space)
	);

	// output packing
	assign m_tdata = {5'd0, res_out.stitch_index, res_out.unknown_flags, res_out.stitch_flag,
		res_out.stitch_y, res_out.stitch_x, res_out.color_index, res_out.thread_color,
		res_out.hoop_code, res_out.version_byte};
	assign m_tuser = res_out.kind;
	assign m_tlast = res_out.last_stitch;

	`ASSERT_NEXT(a_result_lands, clk, arst_n, advance && res_valid, m_tvalid)
	`ASSERT_NEXT(a_stalled_byte_kept, clk, arst_n, valid_s1 && !advance, valid_s1)
	`ASSERT_IMPLY(a_last_only_on_stitch, clk, arst_n, m_tvalid && m_tlast, m_tuser == KIND_STITCH)
	`ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !valid_s1, s_tready)

endmodule
